@@ hw/rtl/lkvc_pkg.sv @@
// shared types and constants for the lru key-value cache
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int KEY_W   = 16;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // register word index within the apb window
    localparam logic REG_CAPACITY = 1'b0;

    // command codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic               command;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] read_value;
        logic               evicted;
        logic [KEY_W-1:0]   evicted_key;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

@@ hw/rtl/lkvc_cell.sv @@
// one recency position of the lru chain: entry storage, key match and shift
`timescale 1ns / 1ps

module lkvc_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lkvc_pkg::cell_ctl_t            ctl,
    input  lkvc_pkg::entry_t               load_entry,
    input  lkvc_pkg::entry_t               nbr_entry,
    input  logic [lkvc_pkg::KEY_W-1:0]     lookup_key,
    input  logic                           hit_in,
    input  logic [lkvc_pkg::VALUE_W-1:0]   value_in,
    output lkvc_pkg::entry_t               entry,
    output logic                           hit_out,
    output logic [lkvc_pkg::VALUE_W-1:0]   value_out
);
    import lkvc_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid_reg;
    logic   valid_next;
    logic   hit_here;

    assign hit_here  = valid_reg && (entry_reg.key == lookup_key);
    assign hit_out   = hit_in | hit_here;
    assign value_out = value_in | (hit_here ? entry_reg.value : '0);
    assign entry     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg | ctl.load;
        priority if (ctl.load)
        begin
            entry_next = load_entry;
        end
        else if (ctl.shift)
        begin
            entry_next = nbr_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ hw/rtl/lru_key_value_cache.sv @@
// lru key-value cache top level: request decode, cell chain control, apb register, result stage
`timescale 1ns / 1ps
// a result beat is registered and appears in the cycle after its request beat is accepted
// throughput: one request per cycle while req_stall is low, set by the combinational match and shift of the cell chain
// a held result stalls the request side only while that result is itself stalled
// reset: all entries invalid, occupancy zero, capacity 16, no result pending
// stored keys and values are not cleared, so no clearing pass is needed

module lru_key_value_cache #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  lkvc_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output lkvc_pkg::rsp_t                rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lkvc_pkg::APB_AW-1:0]   paddr,
    input  logic [lkvc_pkg::APB_DW-1:0]   pwdata,
    output logic [lkvc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import lkvc_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    // capacity register and occupancy
    logic [CAP_W-1:0] capacity_reg;
    logic [CAP_W-1:0] capacity_next;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    // result stage
    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_reg;
    rsp_t rsp_next;

    logic req_fire;
    logic cfg_write;

    // chain wiring: index 0 is the least recent position
    logic                  hit_chain   [0:DEPTH];
    logic [VALUE_W-1:0]    value_chain [0:DEPTH];
    entry_t                cell_entry  [0:DEPTH];
    cell_ctl_t             cell_ctl    [0:DEPTH-1];

    logic                  hit;
    logic                  is_put;
    logic                  full;
    logic                  do_evict;
    logic                  do_insert;
    logic                  do_load;
    logic [IDX_W-1:0]      tail_idx;
    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      eff_cap;
    entry_t                load_entry;

    // ---------------------------------------------------------------
    // apb register port, capacity only changes while the cache is empty
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata    = (paddr[2] == REG_CAPACITY) ? APB_DW'(capacity_reg) : '0;

    always_comb
    begin
        capacity_next = capacity_reg;
        if (cfg_write && (occ_reg == '0))
        begin
            capacity_next = pwdata[CAP_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // handshake: the result register frees up whenever its beat is taken
    // ---------------------------------------------------------------
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign req_fire  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------------------------------------------------------
    // decode of one request against the chain
    // ---------------------------------------------------------------
    assign hit_chain[0]   = 1'b0;
    assign value_chain[0] = '0;
    assign cell_entry[DEPTH] = '0;

    assign hit    = hit_chain[DEPTH];
    assign is_put = (req.command == CMD_PUT);

    // zero capacity acts as one, anything above the chain length as the chain length
    assign cap_ext = CMP_W'(capacity_reg);
    always_comb
    begin
        priority if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > DEPTH_C)
        begin
            eff_cap = DEPTH_C;
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign full      = (CMP_W'(occ_reg) >= eff_cap) && (occ_reg != '0);
    assign do_evict  = req_fire && is_put && !hit && full;
    assign do_insert = req_fire && is_put && !hit && !full;
    assign do_load   = req_fire && (hit || is_put);

    // the entry lands at the most recent end: last used position, or the first free one
    always_comb
    begin
        if (hit || full)
        begin
            tail_idx = IDX_W'(occ_reg - OCC_W'(1));
        end
        else
        begin
            tail_idx = IDX_W'(occ_reg);
        end
    end

    always_comb
    begin
        load_entry.key   = req.key;
        load_entry.value = (is_put) ? req.value : value_chain[DEPTH];
    end

    // ---------------------------------------------------------------
    // cell chain: positions below the tail shift down on an eviction,
    // or from the hit position upward on a hit
    // ---------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            always_comb
            begin
                cell_ctl[gi].load  = do_load && (tail_idx == IDX_W'(gi));
                cell_ctl[gi].shift = req_fire && (IDX_W'(gi) < tail_idx)
                                     && (do_evict || (hit && hit_chain[gi+1]));
            end

            lkvc_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (cell_ctl[gi]),
                .load_entry (load_entry),
                .nbr_entry  (cell_entry[gi+1]),
                .lookup_key (req.key),
                .hit_in     (hit_chain[gi]),
                .value_in   (value_chain[gi]),
                .entry      (cell_entry[gi]),
                .hit_out    (hit_chain[gi+1]),
                .value_out  (value_chain[gi+1])
            );
        end
    endgenerate

    // ---------------------------------------------------------------
    // occupancy and result beat
    // ---------------------------------------------------------------
    always_comb
    begin
        occ_next = occ_reg;
        if (do_insert)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
    end

    always_comb
    begin
        rsp_valid_next = req_fire || (rsp_valid_reg && rsp_stall);
        rsp_next       = rsp_reg;
        if (req_fire)
        begin
            rsp_next.found       = hit;
            rsp_next.read_value  = (hit && !is_put) ? value_chain[DEPTH] : '0;
            rsp_next.evicted     = is_put && !hit && full;
            rsp_next.evicted_key = (is_put && !hit && full) ? cell_entry[0].key : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            capacity_reg  <= capacity_next;
            occ_reg       <= occ_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule
